// ----- hw/rtl/wps_pkg.sv -----
// ----------------------------------------------------------------------------
// wps_pkg
// Types and constants of the weighted pair selector: table geometry, request
// and response words, request codes and register map.
// ----------------------------------------------------------------------------
package wps_pkg;

	localparam int MAX_SITES = 16;
	localparam int RATE_BITS = 32;
	localparam int SUM_W     = 40;
	localparam int SITE_W    = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
	localparam int CNT_W     = $clog2(MAX_SITES + 1);
	localparam int DEPTH     = MAX_SITES * MAX_SITES;
	localparam int ADDR_W    = $clog2(DEPTH);

	// request codes
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SELECT = 1'b1;

	// register map (word index on paddr[2])
	localparam int          PADDR_W          = 3;
	localparam logic        REG_ACTIVE_SITES = 1'b0;
	localparam logic [4:0]  ACTIVE_RESET     = 5'd16;

	typedef struct packed {
		logic        req_type;
		logic [3:0]  from_site;
		logic [3:0]  to_site;
		logic [31:0] rate_value;
		logic [39:0] draw;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [3:0]  chosen_from;
		logic [3:0]  chosen_to;
		logic [39:0] total_rate;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WR   = 4'b0010,
		ST_SEL  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

// ----- hw/rtl/weighted_pair_selector_core.sv -----
// ----------------------------------------------------------------------------
// weighted_pair_selector_core
// Rate table with running total and roulette-wheel pair pick.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one word at a time. A write
//   word (req_type = write) replaces one rate entry and updates the total; a
//   select word walks sites 0..active_sites-1 source-major and returns the
//   first pair whose running (saturating) sum exceeds the draw.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one word per request.
//   A select reads up to n*n entries (n = active sites, at most MAX_SITES = 16)
//   and stops early on a hit. The walk reads the rate memory once per cycle
//   through its single read port, which sets the select time. One request is
//   in flight at a time; the next one is taken once the current word sits in
//   the output register.
//   A stalled receiver holds the output word; a finished request then waits
//   until the output register frees up, and req_ready stays low meanwhile.
//   Reset: all rates read as zero (per-entry valid bits), total is zero,
//   active_sites is 16. No clearing pass is needed.
//   Config: APB register active_sites at address 0; write it only when idle (not enforced by the block).
// ----------------------------------------------------------------------------
module weighted_pair_selector_core
	import wps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	state_t               state_q;
	logic [4:0]           active_q;

	logic [RATE_BITS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]     vld_q;
	logic [RATE_BITS-1:0] rd_data_s1;
	logic                 rd_vld_s1;

	logic [SUM_W-1:0]     total_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SUM_W-1:0]     draw_q;
	logic [RATE_BITS-1:0] rate_q;
	logic [ADDR_W-1:0]    wr_idx_q;
	logic                 wr_ok_q;
	logic [CNT_W-1:0]     n_q;
	logic [SITE_W-1:0]    i_q, j_q;
	logic                 issue_done_q;
	logic                 tag_vld_s1;
	logic [SITE_W-1:0]    ti_s1, tj_s1;
	logic                 tlast_s1;

	logic                 res_found_q;
	logic [3:0]           res_from_q, res_to_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 acc_req, cfg_wr, out_free;
	logic                 req_in_range;
	logic [ADDR_W-1:0]    req_idx, walk_idx, rd_addr;
	logic                 rd_en, sel_issue;
	logic [CNT_W-1:0]     n_req, n_last;
	logic                 i_last, j_last, walk_last;
	logic [RATE_BITS-1:0] old_rate, cur_rate;
	logic [SUM_W:0]       sum_ext;
	logic [SUM_W-1:0]     sum_sat;
	logic                 sel_hit, sel_end;

	assign acc_req   = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_SITES);
	assign prdata = (paddr[2] == REG_ACTIVE_SITES) ? {27'd0, active_q} : 32'd0;

	assign req_in_range = (32'(req.from_site) < 32'(MAX_SITES)) &&
		(32'(req.to_site) < 32'(MAX_SITES));
	assign req_idx  = ADDR_W'(ADDR_W'(req.from_site) * ADDR_W'(MAX_SITES) +
		ADDR_W'(req.to_site));
	assign walk_idx = ADDR_W'(ADDR_W'(i_q) * ADDR_W'(MAX_SITES) + ADDR_W'(j_q));

	assign n_req = (32'(active_q) > 32'(MAX_SITES)) ? CNT_W'(MAX_SITES) : CNT_W'(active_q);
	assign n_last    = n_q - CNT_W'(1);
	assign i_last    = (CNT_W'(i_q) == n_last);
	assign j_last    = (CNT_W'(j_q) == n_last);
	assign walk_last = i_last && j_last;

	// walk accumulation on the word read last cycle
	assign old_rate = rd_vld_s1 ? rd_data_s1 : '0;
	assign cur_rate = old_rate;
	assign sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(cur_rate);
	assign sum_sat  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
	assign sel_hit  = (state_q == ST_SEL) && tag_vld_s1 && (sum_sat > draw_q);
	assign sel_end  = (state_q == ST_SEL) && tag_vld_s1 && (sel_hit || tlast_s1);

	assign sel_issue = (state_q == ST_SEL) && !issue_done_q && !sel_end;
	assign rd_en     = (acc_req && (req.req_type == REQ_WRITE)) || sel_issue;
	assign rd_addr   = (state_q == ST_IDLE) ? req_idx : walk_idx;

	// rate memory: one write and one registered read port; requests never
	// overlap, so a read never meets a pending write to the same entry
	always_ff @(posedge clk) begin
		if (state_q == ST_WR && wr_ok_q) begin
			mem[wr_idx_q] <= rate_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (state_q == ST_WR && wr_ok_q) begin
				vld_q[wr_idx_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc_req) begin
			draw_q   <= req.draw;
			rate_q   <= RATE_BITS'(req.rate_value);
			wr_idx_q <= req_idx;
			wr_ok_q  <= req_in_range;
			n_q      <= n_req;
		end
		if (sel_issue) begin
			ti_s1    <= i_q;
			tj_s1    <= j_q;
			tlast_s1 <= walk_last;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_q     <= ACTIVE_RESET;
			total_q      <= '0;
			sum_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			issue_done_q <= 1'b0;
			tag_vld_s1   <= 1'b0;
			res_found_q  <= 1'b0;
			res_from_q   <= '0;
			res_to_q     <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (cfg_wr) begin
				active_q <= pwdata[4:0];
			end
			tag_vld_s1 <= sel_issue;
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_req) begin
						sum_q        <= '0;
						i_q          <= '0;
						j_q          <= '0;
						issue_done_q <= 1'b0;
						res_found_q  <= 1'b0;
						res_from_q   <= '0;
						res_to_q     <= '0;
						if (req.req_type == REQ_WRITE) begin
							state_q <= ST_WR;
						end else if (n_req == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SEL;
						end
					end
				end
				ST_WR: begin
					if (wr_ok_q) begin
						total_q <= total_q - SUM_W'(old_rate) + SUM_W'(rate_q);
					end
					res_found_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_SEL: begin
					if (sel_issue) begin
						if (walk_last) begin
							issue_done_q <= 1'b1;
						end
						if (j_last) begin
							j_q <= '0;
							i_q <= i_q + SITE_W'(1);
						end else begin
							j_q <= j_q + SITE_W'(1);
						end
					end
					if (tag_vld_s1) begin
						sum_q <= sum_sat;
					end
					if (sel_hit) begin
						res_found_q <= 1'b1;
						res_from_q  <= 4'(ti_s1);
						res_to_q    <= 4'(tj_s1);
					end
					if (sel_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_q.found       <= res_found_q;
						rsp_q.chosen_from <= res_from_q;
						rsp_q.chosen_to   <= res_to_q;
						rsp_q.total_rate  <= total_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_sel_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEL) |-> (n_q != '0))
		else $error("walk running with no active sites");

	a_write_goes_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_req && req.req_type == REQ_WRITE) |=> (state_q == ST_WR))
		else $error("write request did not enter update state");

	a_sum_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SEL) && $past(state_q == ST_SEL)) |-> (sum_q >= $past(sum_q)))
		else $error("walk sum decreased");

	a_miss_zero_sites: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.found) |-> (rsp_q.chosen_from == '0 && rsp_q.chosen_to == '0))
		else $error("miss reports nonzero sites");

	a_write_found: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q == ST_WR)) |-> res_found_q)
		else $error("write result not flagged found");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives request words into weighted_pair_selector_core and checks every
// response against a cycle-free predictor of the rate table, the running
// total and the roulette-wheel pick. Runs several active_sites settings,
// random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench
	import wps_pkg::*;
();

	localparam int               STALL_LIMIT = 5000;
	localparam int               TAIL_CYCLES = 300;
	localparam int               HOLD_AT     = 250;
	localparam int               HOLD_CYCLES = 400;
	localparam int               CALM_FROM   = 400;
	localparam int               CALM_TO     = 520;
	localparam int               IDLE_PCT    = 22;
	localparam bit [SUM_W:0]     SUM_MAX     = (41'd1 << SUM_W) - 41'd1;
	localparam logic [PADDR_W-1:0] ADDR_ACTIVE_SITES = {REG_ACTIVE_SITES, 2'b00};

	// Rate table shadow, total and pick prediction; checks responses in order.
	class pair_pick_scoreboard;
		bit [RATE_BITS-1:0] rates [DEPTH];
		bit [SUM_W-1:0]     total;
		logic [4:0]         sites;
		rsp_t               due_q [$];
		int                 errors;
		int                 n_writes;
		int                 n_selects;
		int                 n_picks;

		function new();
			foreach (rates[k])
				rates[k] = '0;
			total     = '0;
			sites     = ACTIVE_RESET;
			errors    = 0;
			n_writes  = 0;
			n_selects = 0;
			n_picks   = 0;
		endfunction

		function void set_sites(logic [4:0] v);
			sites = v;
		endfunction

		function int walk_count();
			return (sites > MAX_SITES) ? MAX_SITES : int'(sites);
		endfunction

		// sum of rates the walk covers, saturated like the walk itself
		function bit [SUM_W:0] active_weight();
			bit [SUM_W:0] acc;
			int           n;
			acc = '0;
			n = walk_count();
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					acc = acc + rates[i * MAX_SITES + j];
					if (acc > SUM_MAX)
						acc = SUM_MAX;
				end
			return acc;
		endfunction

		function rsp_t pick_for(req_t w);
			rsp_t         r;
			int           idx;
			int           n;
			bit [SUM_W:0] acc;
			bit           hit;
			r = '0;
			if (w.req_type == REQ_WRITE) begin
				n_writes++;
				if (w.from_site < MAX_SITES && w.to_site < MAX_SITES) begin
					idx = int'(w.from_site) * MAX_SITES + int'(w.to_site);
					total = total - SUM_W'(rates[idx]) + SUM_W'(w.rate_value[RATE_BITS-1:0]);
					rates[idx] = w.rate_value[RATE_BITS-1:0];
				end
				r.found = 1'b1;
			end else begin
				n_selects++;
				n = walk_count();
				acc = '0;
				hit = 1'b0;
				for (int i = 0; i < n && !hit; i++)
					for (int j = 0; j < n && !hit; j++) begin
						acc = acc + rates[i * MAX_SITES + j];
						if (acc > SUM_MAX)
							acc = SUM_MAX;
						if (acc > {1'b0, w.draw}) begin
							hit = 1'b1;
							r.chosen_from = 4'(i);
							r.chosen_to   = 4'(j);
						end
					end
				r.found = hit;
				if (hit)
					n_picks++;
			end
			r.total_rate = total;
			return r;
		endfunction

		function void note_input(req_t w);
			due_q.insert(due_q.size(), pick_for(w));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (due_q.size() == 0) begin
				$error("response word with no request pending");
				errors++;
				return;
			end
			want = due_q.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				errors++;
			end
			if (got.chosen_from !== want.chosen_from) begin
				$error("chosen_from: expected %0d, got %0d", want.chosen_from, got.chosen_from);
				errors++;
			end
			if (got.chosen_to !== want.chosen_to) begin
				$error("chosen_to: expected %0d, got %0d", want.chosen_to, got.chosen_to);
				errors++;
			end
			if (got.total_rate !== want.total_rate) begin
				$error("total_rate: expected %h, got %h", want.total_rate, got.total_rate);
				errors++;
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [31:0]        pwdata    = '0;
	logic [31:0]        prdata;
	logic               pready;

	pair_pick_scoreboard sb = new();
	int n_in  = 0;
	int n_cfg = 0;
	bit held  = 1'b0;

	weighted_pair_selector_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// window of words with no idling on either side
	function automatic bit calm();
		return n_in >= CALM_FROM && n_in < CALM_TO;
	endfunction

	function automatic req_t make_word(logic kind, int from_s, int to_s,
			logic [31:0] rate, logic [39:0] draw);
		req_t w;
		w.req_type   = kind;
		w.from_site  = 4'(from_s);
		w.to_site    = 4'(to_s);
		w.rate_value = rate;
		w.draw       = draw;
		return w;
	endfunction

	function automatic req_t random_word();
		req_t         w;
		int           n;
		int           roll;
		bit [63:0]    r64;
		bit [SUM_W:0] s;
		w.req_type   = ($urandom_range(0, 99) < 45) ? REQ_WRITE : REQ_SELECT;
		w.from_site  = 4'($urandom_range(0, 15));
		w.to_site    = 4'($urandom_range(0, 15));
		w.rate_value = $urandom;
		r64 = {$urandom, $urandom};
		w.draw = r64[SUM_W-1:0];
		if (w.req_type == REQ_WRITE) begin
			// keep half the writes inside the walked square
			n = sb.walk_count();
			if (n > 0 && $urandom_range(0, 1) == 1) begin
				w.from_site = 4'($urandom_range(0, n - 1));
				w.to_site   = 4'($urandom_range(0, n - 1));
			end
			roll = $urandom_range(0, 99);
			if (roll < 10)
				w.rate_value = '0;
			else if (roll < 15)
				w.rate_value = '1;
			else if (roll < 30)
				w.rate_value = 32'($urandom_range(1, 255));
		end else begin
			s = sb.active_weight();
			roll = $urandom_range(0, 99);
			if (roll < 75 && s != 0)
				w.draw = SUM_W'(r64 % 64'(s));
			else if (roll < 85)
				w.draw = SUM_W'(s) + SUM_W'($urandom_range(0, 3));
			else if (roll < 90)
				w.draw = '0;
			else if (roll < 95)
				w.draw = '1;
		end
		return w;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input req_t w);
		if (!calm() && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < IDLE_PCT);
		end
		req       <= w;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_input(w);
		n_in++;
		@(negedge clk);
	endtask

	task automatic quiesce();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_active_sites(input logic [4:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ACTIVE_SITES;
		pwdata  <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.set_sites(v);
		n_cfg++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	always @(posedge clk)
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(rsp);

	initial begin : receiver
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			// one long hold-off so the output register fills and req_ready drops
			if (!held && n_in >= HOLD_AT) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_ready <= calm() || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [4:0] plan_sites [9];
		int         plan_items [9];
		plan_sites = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd17, 5'd7, 5'd16, 5'd16};
		plan_items = '{200, 60, 60, 30, 100, 100, 100, 100, 100};
		plan_sites[7] = 5'($urandom_range(1, 16));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, extreme rates and corners, overwrite, zero entries
		send_word(make_word(REQ_SELECT, 15, 15, '1, '0));
		send_word(make_word(REQ_WRITE, 0, 0, 32'hFFFF_FFFF, '1));
		send_word(make_word(REQ_WRITE, 15, 15, 32'd1, '0));
		send_word(make_word(REQ_WRITE, 15, 0, 32'd0, 40'hAA_AAAA_AAAA));
		send_word(make_word(REQ_WRITE, 3, 7, 32'h8000_0000, 40'h55_5555_5555));
		send_word(make_word(REQ_SELECT, 0, 0, '0, '0));
		send_word(make_word(REQ_SELECT, 0, 0, '0, 40'hFF_FFFF_FFFE));
		send_word(make_word(REQ_SELECT, 0, 0, '0, 40'hFF_FFFF_FFFF));
		send_word(make_word(REQ_SELECT, 0, 0, '0, SUM_W'(sb.active_weight() - 1)));
		send_word(make_word(REQ_SELECT, 0, 0, '0, SUM_W'(sb.active_weight())));
		send_word(make_word(REQ_SELECT, 0, 0, '0, '1));
		send_word(make_word(REQ_WRITE, 0, 0, 32'h0001_2345, '0));
		send_word(make_word(REQ_WRITE, 0, 0, 32'd0, '0));
		// (0,0) now zero: draw 0 must skip to the next nonzero entry
		send_word(make_word(REQ_SELECT, 0, 0, '0, '0));
		send_word(make_word(REQ_WRITE, 15, 15, 32'hFFFF_FFFF, '0));
		send_word(make_word(REQ_SELECT, 9, 6, 32'h5A5A_5A5A, SUM_W'(sb.active_weight() - 1)));
		send_word(make_word(REQ_WRITE, 0, 0, 32'd3, '0));

		for (int p = 0; p < 9; p++) begin
			quiesce();
			write_active_sites(plan_sites[p]);
			repeat (plan_items[p])
				send_word(random_word());
		end

		quiesce();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.pending() != 0) begin
			$error("%0d responses never arrived", sb.pending());
			sb.errors++;
		end

		$display("%0d request words: %0d writes, %0d selects (%0d picks, %0d misses)",
			n_in, sb.n_writes, sb.n_selects, sb.n_picks, sb.n_selects - sb.n_picks);
		$display("%0d active_sites writes, including 0, 1, 16 and above the table size", n_cfg);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
